### src/cpc_pkg.sv
`timescale 1ns / 1ps

package cpc_pkg;

   // event codes
   typedef enum logic [2:0] {
      OP_ALLOCATE  = 3'd0,
      OP_RELEASE   = 3'd1,
      OP_SCHEDULE  = 3'd2,
      OP_FINISH    = 3'd3,
      OP_SET_DEPTH = 3'd4
   } op_type;

   // register word indexes
   typedef enum logic {
      CSR_DECODE_SLACK = 1'b0,
      CSR_FIXED_EXTRA  = 1'b1
   } csr_index_type;

   localparam int OP_WIDTH       = 3;
   localparam int FIELD_WIDTH    = 8;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int RESET_LIMIT = 6;
   localparam logic [FIELD_WIDTH-1:0] RESET_DECODE_SLACK = 8'd4;
   localparam logic [FIELD_WIDTH-1:0] RESET_FIXED_EXTRA  = 8'd5;

   typedef struct packed {
      logic                   slot_free;
      logic                   error;
      logic [FIELD_WIDTH-1:0] outstanding_count;
      logic [FIELD_WIDTH-1:0] in_flight_count;
      logic [FIELD_WIDTH-1:0] current_limit;
   } result_type;

endpackage

### src/cpc_req_if.sv
`timescale 1ns / 1ps

interface cpc_req_if
   import cpc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    operation;
   logic [FIELD_WIDTH-1:0] reorder_depth;

   modport source (output valid, output operation, output reorder_depth, input ready);
   modport sink (input valid, input operation, input reorder_depth, output ready);
endinterface

### src/cpc_rsp_if.sv
`timescale 1ns / 1ps

interface cpc_rsp_if
   import cpc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   slot_free;
   logic                   error;
   logic [FIELD_WIDTH-1:0] outstanding_count;
   logic [FIELD_WIDTH-1:0] in_flight_count;
   logic [FIELD_WIDTH-1:0] current_limit;

   modport source (output valid, output slot_free, output error, output outstanding_count,
                   output in_flight_count, output current_limit, input ready);
   modport sink (input valid, input slot_free, input error, input outstanding_count,
                 input in_flight_count, input current_limit, output ready);
endinterface

### src/cpc_core.sv
`timescale 1ns / 1ps

module cpc_core
   import cpc_pkg::*;
#(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [OP_WIDTH-1:0]    operation,
   input  logic [FIELD_WIDTH-1:0] reorder_depth,
   input  logic [FIELD_WIDTH-1:0] decode_slack,
   input  logic [FIELD_WIDTH-1:0] fixed_extra,
   output result_type             result
);
   localparam int CW = COUNT_WIDTH;
   localparam int TW = ((CW > FIELD_WIDTH) ? CW : FIELD_WIDTH) + 1;
   localparam int COUNT_MAX_INT = (1 << CW) - 1;
   localparam logic [CW-1:0] COUNT_MAX = CW'(COUNT_MAX_INT);
   localparam logic [CW-1:0] LIMIT_INIT =
      (RESET_LIMIT > COUNT_MAX_INT) ? COUNT_MAX : CW'(RESET_LIMIT);

   logic [CW-1:0] outstanding_ff, outstanding_in;
   logic [CW-1:0] in_flight_ff, in_flight_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [CW-1:0] pending_ff, pending_in;
   logic [CW-1:0] out_dec;
   logic [TW-1:0] target_wide;
   logic [CW-1:0] target;
   logic          error;

   always_comb begin
      target_wide = TW'(reorder_depth) + TW'(fixed_extra);
      target = (target_wide > TW'(COUNT_MAX)) ? COUNT_MAX : target_wide[CW-1:0];
      out_dec = outstanding_ff - CW'(1);
      outstanding_in = outstanding_ff;
      in_flight_in = in_flight_ff;
      limit_in = limit_ff;
      pending_in = pending_ff;
      error = 1'b0;
      unique case (operation)
         OP_ALLOCATE: begin
            if (outstanding_ff == COUNT_MAX) error = 1'b1;
            else outstanding_in = outstanding_ff + CW'(1);
         end
         OP_RELEASE: begin
            if (outstanding_ff == '0) begin
               error = 1'b1;
            end else begin
               outstanding_in = out_dec;
               // shrink only once the outstanding count has drained
               if (pending_ff < limit_ff && out_dec <= pending_ff) limit_in = pending_ff;
            end
         end
         OP_SCHEDULE: begin
            if (in_flight_ff == COUNT_MAX) error = 1'b1;
            else in_flight_in = in_flight_ff + CW'(1);
         end
         OP_FINISH: begin
            if (in_flight_ff == '0) error = 1'b1;
            else in_flight_in = in_flight_ff - CW'(1);
         end
         OP_SET_DEPTH: begin
            if (target > limit_ff) limit_in = target;
            pending_in = target;
         end
         default: begin
         end
      endcase

      result.slot_free = (TW'(in_flight_in) + TW'(outstanding_in)) <
                         (TW'(limit_in) + TW'(decode_slack));
      result.error = error;
      result.outstanding_count = FIELD_WIDTH'(outstanding_in);
      result.in_flight_count = FIELD_WIDTH'(in_flight_in);
      result.current_limit = FIELD_WIDTH'(limit_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         in_flight_ff <= '0;
         limit_ff <= LIMIT_INIT;
         pending_ff <= LIMIT_INIT;
      end else if (accept) begin
         outstanding_ff <= outstanding_in;
         in_flight_ff <= in_flight_in;
         limit_ff <= limit_in;
         pending_ff <= pending_in;
      end
   end

endmodule

### src/picture_buffer_credit_pacer.sv
`timescale 1ns / 1ps

// channel | direction | handshake        | payload
// req     | in        | valid/ready      | operation, reorder_depth
// rsp     | out       | valid/ready      | slot_free, error, counts, current_limit
// csr     | in        | apb psel/penable | decode_slack @0x0, fixed_extra @0x4
//
// one item per cycle unless rsp stalls; a result appears in the cycle after its item is taken.
// counts update at the accepting edge, the result sits in an output register.
// req.ready is high while the output register is empty or being drained,
// so a held result stalls input only when rsp.ready is low.
// synchronous reset: counts zero, limit and pending limit six (clamped to count max), registers 4 and 5.
module picture_buffer_credit_pacer
   import cpc_pkg::*;
#(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   cpc_req_if.sink                   req,
   cpc_rsp_if.source                 rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);
   logic [FIELD_WIDTH-1:0] slack_ff, extra_ff;
   logic                   rsp_valid_ff;
   result_type             rsp_data_ff, result;
   logic                   accept;
   logic                   csr_write;
   csr_index_type          csr_index;

   assign csr_pready = 1'b1;
   assign csr_index = csr_index_type'(csr_paddr[2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         CSR_DECODE_SLACK: csr_prdata = CSR_DATA_WIDTH'(slack_ff);
         CSR_FIXED_EXTRA:  csr_prdata = CSR_DATA_WIDTH'(extra_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= RESET_DECODE_SLACK;
         extra_ff <= RESET_FIXED_EXTRA;
      end else if (csr_write) begin
         if (csr_index == CSR_DECODE_SLACK) slack_ff <= csr_pwdata[FIELD_WIDTH-1:0];
         else extra_ff <= csr_pwdata[FIELD_WIDTH-1:0];
      end
   end

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   cpc_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req.operation),
      .reorder_depth(req.reorder_depth),
      .decode_slack (slack_ff),
      .fixed_extra  (extra_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= result;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.slot_free = rsp_data_ff.slot_free;
   assign rsp.error = rsp_data_ff.error;
   assign rsp.outstanding_count = rsp_data_ff.outstanding_count;
   assign rsp.in_flight_count = rsp_data_ff.in_flight_count;
   assign rsp.current_limit = rsp_data_ff.current_limit;

endmodule
